// ----- design/pulse_period_moving_average_core_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef PULSE_PERIOD_MOVING_AVERAGE_CORE_MACROS_SVH
`define PULSE_PERIOD_MOVING_AVERAGE_CORE_MACROS_SVH

// Clocked property that is ignored while reset is asserted.
`define PPMA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked property that is checked during reset as well.
`define PPMA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// ----- design/ppma_pkg.sv -----
`timescale 1ns / 1ps

package ppma_pkg;

    // Field and register widths.
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned PDATA_W  = 32;
    localparam int unsigned PADDR_W  = 3;

    // Register map: word index taken from paddr[2].
    localparam logic REG_STALL_TIMEOUT = 1'b0;

    // Reset value of the stall timeout, in microseconds.
    localparam logic [TIME_W-1:0] STALL_TIMEOUT_RESET = 32'd1000000;

endpackage

// ----- design/pulse_period_moving_average_core.sv -----
`timescale 1ns / 1ps

// Tachometer period averager. A beat with i_func low is a pulse edge: the time since
// the previous pulse goes into a window of the last DEPTH periods held in a one-port
// RAM, and a running sum is updated. A beat with i_func high is a speed query and
// yields one result beat: the truncated mean of the stored periods, or 0 when the
// window is empty or more than the stall timeout has passed since the last pulse.
// Items are taken one at a time. A pulse does a RAM read, then the
// read-modify-write of sum and window. A query whose answer is 0 goes straight to
// ST_DONE; otherwise it first passes through the restoring divider, which
// retires one quotient bit per cycle; a result waiting in the output register
// holds the next query back only in ST_DONE, its last state.
module pulse_period_moving_average_core #(
    parameter int unsigned DEPTH = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Item channel.
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_func,
    input  logic [ppma_pkg::TIME_W-1:0]    i_now_us,
    // Result channel.
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [ppma_pkg::TIME_W-1:0]    o_avg_period_us,
    // Register port.
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ppma_pkg::PADDR_W-1:0]   paddr,
    input  logic [ppma_pkg::PDATA_W-1:0]   pwdata,
    output logic [ppma_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);
    import ppma_pkg::*;

    localparam int unsigned SLOT_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
    localparam int unsigned SUM_W   = TIME_W + $clog2(DEPTH);
    localparam int unsigned STEP_W  = $clog2(SUM_W + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_PULSE = 2'd1;
    localparam logic [1:0] ST_DIV   = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]          r_state, n_state;
    logic [SLOT_W-1:0]   r_slot, n_slot;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [SUM_W-1:0]    r_sum, n_sum;
    logic [TIME_W-1:0]   r_last, n_last;
    logic [TIME_W-1:0]   r_now, n_now;
    logic [TIME_W-1:0]   r_timeout;
    logic [SUM_W-1:0]    r_quo, n_quo;
    logic [CNT_W-1:0]    r_rem, n_rem;
    logic [STEP_W-1:0]   r_step, n_step;
    logic                r_out_valid, n_out_valid;
    logic [TIME_W-1:0]   r_out_data, n_out_data;

    // Window RAM with one write and one registered read.
    logic [TIME_W-1:0]   r_window [DEPTH];
    logic [TIME_W-1:0]   r_rd_data;
    logic                mem_we;
    logic [TIME_W-1:0]   mem_wdata;

    logic                in_accept;
    logic                out_free;
    logic                win_full;
    logic [TIME_W-1:0]   since;
    logic [CNT_W:0]      rem_shift;
    logic                cfg_write;

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign win_full  = (r_count == CNT_W'(DEPTH));
    assign since     = i_now_us - r_last;
    assign rem_shift = {r_rem, r_quo[SUM_W-1]};
    assign mem_wdata = r_now - r_last;
    assign mem_we    = (r_state == ST_PULSE);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_window[r_slot] <= mem_wdata;
        end
        r_rd_data <= r_window[r_slot];
    end

    // Sequencer, window bookkeeping and the serial divider.
    always_comb begin
        n_state     = r_state;
        n_slot      = r_slot;
        n_count     = r_count;
        n_sum       = r_sum;
        n_last      = r_last;
        n_now       = r_now;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_step      = r_step;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_now = i_now_us;
                    if (!i_func) begin
                        n_state = ST_PULSE;
                    end else if (since <= r_timeout && r_count != '0) begin
                        n_quo   = r_sum;
                        n_rem   = '0;
                        n_step  = STEP_W'(SUM_W);
                        n_state = ST_DIV;
                    end else begin
                        n_quo   = '0;
                        n_state = ST_DONE;
                    end
                end
            end
            ST_PULSE: begin
                // The oldest period leaves once the window is full.
                if (win_full) begin
                    n_sum = r_sum - SUM_W'(r_rd_data) + SUM_W'(mem_wdata);
                end else begin
                    n_sum   = r_sum + SUM_W'(mem_wdata);
                    n_count = r_count + CNT_W'(1);
                end
                n_slot  = (r_slot == SLOT_W'(DEPTH - 1)) ? '0 : r_slot + SLOT_W'(1);
                n_last  = r_now;
                n_state = ST_IDLE;
            end
            ST_DIV: begin
                // One restoring step: the remainder always stays below the count.
                if (rem_shift >= {1'b0, r_count}) begin
                    n_rem = CNT_W'(rem_shift - {1'b0, r_count});
                    n_quo = {r_quo[SUM_W-2:0], 1'b1};
                end else begin
                    n_rem = rem_shift[CNT_W-1:0];
                    n_quo = {r_quo[SUM_W-2:0], 1'b0};
                end
                n_step = r_step - STEP_W'(1);
                if (r_step == STEP_W'(1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_quo[TIME_W-1:0];
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_slot      <= '0;
            r_count     <= '0;
            r_sum       <= '0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_slot      <= n_slot;
            r_count     <= n_count;
            r_sum       <= n_sum;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_now      <= n_now;
        r_quo      <= n_quo;
        r_rem      <= n_rem;
        r_step     <= n_step;
        r_out_data <= n_out_data;
    end

    // Register port: one word, written on the access phase.
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= STALL_TIMEOUT_RESET;
        end else if (cfg_write && paddr[2] == REG_STALL_TIMEOUT) begin
            r_timeout <= pwdata;
        end
    end

    assign prdata = (paddr[2] == REG_STALL_TIMEOUT) ? r_timeout : '0;
    assign pready = 1'b1;

    assign o_in_stall      = (r_state != ST_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_avg_period_us = r_out_data;

endmodule

// ----- design/ppma_checker.sv -----
`timescale 1ns / 1ps
`include "pulse_period_moving_average_core_macros.svh"

module ppma_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           o_in_stall,
    input  logic                           i_func,
    input  logic                           o_out_valid,
    input  logic                           i_out_stall,
    input  logic [ppma_pkg::TIME_W-1:0]    o_avg_period_us,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ppma_pkg::PADDR_W-1:0]   paddr,
    input  logic [ppma_pkg::PDATA_W-1:0]   pwdata,
    input  logic [ppma_pkg::PDATA_W-1:0]   prdata,
    input  logic                           pready
);
    import ppma_pkg::*;

    logic in_accept;
    logic timeout_write;

    assign in_accept     = i_in_valid && !o_in_stall;
    assign timeout_write = psel && penable && pwrite && pready
                           && paddr[2] == REG_STALL_TIMEOUT;

    // A held result beat keeps its value.
    `PPMA_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_avg_period_us), "result changed while stalled")
    // Items are taken one at a time.
    `PPMA_ASSERT(a_one_at_a_time, i_clk, i_rst_n, in_accept |=> o_in_stall, "item taken while busy")
    // A pulse never produces a result beat.
    `PPMA_ASSERT(a_pulse_silent, i_clk, i_rst_n, in_accept && !i_func && !o_out_valid |=> !o_out_valid, "pulse produced a result")
    // The timeout register reads back what was written.
    `PPMA_ASSERT(a_cfg_readback, i_clk, i_rst_n, timeout_write ##1 (paddr[2] == REG_STALL_TIMEOUT) |-> prdata == $past(pwdata), "timeout readback mismatch")

endmodule

bind pulse_period_moving_average_core ppma_checker u_ppma_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .i_func          (i_func),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_avg_period_us (o_avg_period_us),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
);
